// ----- rtl/pud_pkg.sv -----
package pud_pkg;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharPct   = 8'h25;
   localparam logic [7:0] CharSpace = 8'h20;
   // an escape spelling 0x30..0x39 is passed through as literal text
   localparam logic [3:0] DigitHiNibble = 4'h3;
   localparam logic [3:0] DigitLoMax    = 4'h9;

   typedef enum logic [2:0] {
      EscIdle  = 3'b001,
      EscPct   = 3'b010,
      EscDigit = 3'b100
   } esc_state_type;

   // up to three output bytes caused by one input byte, lowest index first
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      cnt;
      logic            msg_end;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_digit(logic [7:0] c);
      hex_type r;
      r.ok  = 1'b0;
      r.val = c[3:0];
      if (c[7:4] == 4'h3 && c[3:0] <= 4'h9) begin
         r.ok = 1'b1;
      end else if ((c[7:4] == 4'h4 || c[7:4] == 4'h6) && c[3:0] >= 4'h1 && c[3:0] <= 4'h6) begin
         r.ok  = 1'b1;
         r.val = c[3:0] + 4'd9;
      end
      return r;
   endfunction

   function automatic bundle_type append_byte(bundle_type bd, logic [7:0] b);
      bundle_type r;
      r = bd;
      case (bd.cnt)
         2'd0: begin
            r.data[0] = b;
         end
         2'd1: begin
            r.data[1] = b;
         end
         default: begin
            r.data[2] = b;
         end
      endcase
      r.cnt = bd.cnt + 2'd1;
      return r;
   endfunction

endpackage

// ----- rtl/pud_front.sv -----
module pud_front
   import pud_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   input  queue_status_type q_status,
   output logic             q_push,
   output bundle_type       q_bundle
);

   esc_state_type state_ff, state_in;
   logic [7:0]    held_ff, held_in;
   logic          accept;
   logic          run_plain;
   hex_type       hb, hh;
   bundle_type    bd;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      bd        = '0;
      state_in  = state_ff;
      held_in   = held_ff;
      run_plain = 1'b0;
      hb        = hex_digit(req_tdata);
      hh        = hex_digit(held_ff);
      case (state_ff)
         EscPct: begin
            if (hb.ok) begin
               held_in  = req_tdata;
               state_in = EscDigit;
            end else begin
               bd        = append_byte(bd, CharPct);
               state_in  = EscIdle;
               run_plain = 1'b1;
            end
         end
         EscDigit: begin
            state_in = EscIdle;
            if (hb.ok && hh.ok) begin
               if (hh.val == DigitHiNibble && hb.val <= DigitLoMax) begin
                  bd = append_byte(bd, CharPct);
                  bd = append_byte(bd, held_ff);
                  bd = append_byte(bd, req_tdata);
               end else begin
                  bd = append_byte(bd, {hh.val, hb.val});
               end
            end else begin
               bd        = append_byte(bd, CharPct);
               bd        = append_byte(bd, held_ff);
               run_plain = 1'b1;
            end
         end
         default: begin
            state_in  = EscIdle;
            run_plain = 1'b1;
         end
      endcase

      if (run_plain) begin
         if (req_tdata == CharPlus) begin
            bd = append_byte(bd, CharSpace);
         end else if (req_tdata == CharPct) begin
            state_in = EscPct;
         end else begin
            bd = append_byte(bd, req_tdata);
         end
      end

      // flush a pending escape at the end of the message
      if (req_tlast) begin
         if (state_in == EscPct) begin
            bd = append_byte(bd, CharPct);
         end else if (state_in == EscDigit) begin
            bd = append_byte(bd, CharPct);
            bd = append_byte(bd, held_in);
         end
         state_in = EscIdle;
      end
      bd.msg_end = req_tlast;
   end

   assign q_push   = accept && (bd.cnt != 2'd0);
   assign q_bundle = bd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EscIdle;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |-> q_push)
      else $error("message end transfer produced no output");

   a_end_idles: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> state_ff == EscIdle)
      else $error("escape still pending after message end");

endmodule

// ----- rtl/pud_queue.sv -----
module pud_queue
   import pud_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       push_bundle,
   input  logic             pop,
   output bundle_type       head_bundle,
   output queue_status_type status
);

   bundle_type       mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = count_ff == QCntW'(QDepth);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_bundle  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("push into full queue");

endmodule

// ----- rtl/pud_back.sv -----
module pud_back
   import pud_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       head_bundle,
   input  queue_status_type q_status,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff, done_ff;
   logic       advance, take, at_last;
   logic [7:0] cur_byte;

   assign advance = !valid_ff || rsp_tready;
   assign take    = advance && !q_status.empty;
   assign at_last = idx_ff == (head_bundle.cnt - 2'd1);
   assign q_pop   = take && at_last;

   always_comb begin
      case (idx_ff)
         2'd0: begin
            cur_byte = head_bundle.data[0];
         end
         2'd1: begin
            cur_byte = head_bundle.data[1];
         end
         default: begin
            cur_byte = head_bundle.data[2];
         end
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = take;
      end
      if (take) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= cur_byte;
         last_ff <= at_last;
         done_ff <= at_last && head_bundle.msg_end;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

   a_idx_mid_bundle: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> !q_status.empty)
      else $error("byte index advanced with no bundle queued");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> idx_ff < head_bundle.cnt)
      else $error("byte index past bundle length");

endmodule

// ----- rtl/percent_url_decoder_core.sv -----
// URL percent-decoder. One encoded byte is taken per transfer on req_*; '+' turns into
// a space, '%' plus two hex digits into the byte they spell (escapes that spell an
// ASCII digit, and broken escapes, come out as literal text), and any escape still
// open at req_tlast is flushed literally. Each input byte gives zero to three output
// bytes; rsp_tlast marks the last one caused by that input byte and rsp_tuser the
// last byte of the message. Input is taken at one byte per cycle while the 4-entry
// queue between the classifier and the output serializer has room; output runs at
// one byte per cycle while rsp_tready is high and the queue holds bytes. An accepted
// input byte is first written into the queue, and its first output byte is then
// loaded into the output register.
module percent_url_decoder_core
   import pud_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // message_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser    // message_done
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   bundle_type       push_bundle, head_bundle;

   pud_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_bundle   (push_bundle)
   );

   pud_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_bundle (push_bundle),
      .pop         (q_pop),
      .head_bundle (head_bundle),
      .status      (q_status)
   );

   pud_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_bundle (head_bundle),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ----- sim/percent_url_decoder_core_tb.sv -----
`timescale 1ns / 100ps
module percent_url_decoder_core_tb;
   import pud_pkg::*;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       message_done;
   } decoded_type;

   class decode_checker_type;
      esc_state_type esc_phase;
      logic [7:0]    held_digit;
      decoded_type   expected_bytes[$];
      logic [7:0]    run_bytes[$];
      int            errors;
      int            checked;
      int            escapes;
      int            digit_escapes;
      int            messages;

      function new();
         esc_phase     = EscIdle;
         held_digit    = '0;
         errors        = 0;
         checked       = 0;
         escapes       = 0;
         digit_escapes = 0;
         messages      = 0;
      endfunction

      function int hex_value(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
         if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
         if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
         return -1;
      endfunction

      function void take_plain(logic [7:0] b);
         if (b == CharPlus) begin
            run_bytes.push_back(CharSpace);
         end else if (b == CharPct) begin
            esc_phase = EscPct;
         end else begin
            run_bytes.push_back(b);
         end
      endfunction

      // works out the decoded bytes caused by one accepted input byte
      function void note_encoded(logic [7:0] b, logic msg_end);
         int          hi;
         int          lo;
         logic [7:0]  spelled;
         decoded_type d;
         run_bytes.delete();
         case (esc_phase)
            EscPct: begin
               if (hex_value(b) >= 0) begin
                  held_digit = b;
                  esc_phase  = EscDigit;
               end else begin
                  esc_phase = EscIdle;
                  run_bytes.push_back(CharPct);
                  take_plain(b);
               end
            end
            EscDigit: begin
               hi        = hex_value(held_digit);
               lo        = hex_value(b);
               esc_phase = EscIdle;
               if (hi >= 0 && lo >= 0) begin
                  spelled = 8'(hi * 16 + lo);
                  // an escape that spells an ASCII digit stays literal text
                  if (spelled >= 8'h30 && spelled <= 8'h39) begin
                     run_bytes.push_back(CharPct);
                     run_bytes.push_back(held_digit);
                     run_bytes.push_back(b);
                     digit_escapes++;
                  end else begin
                     run_bytes.push_back(spelled);
                     escapes++;
                  end
               end else begin
                  run_bytes.push_back(CharPct);
                  run_bytes.push_back(held_digit);
                  take_plain(b);
               end
            end
            default: begin
               esc_phase = EscIdle;
               take_plain(b);
            end
         endcase
         if (msg_end) begin
            // flush an open escape
            if (esc_phase == EscPct) begin
               run_bytes.push_back(CharPct);
            end else if (esc_phase == EscDigit) begin
               run_bytes.push_back(CharPct);
               run_bytes.push_back(held_digit);
            end
            esc_phase  = EscIdle;
            held_digit = '0;
            messages++;
         end
         foreach (run_bytes[i]) begin
            d.out_byte     = run_bytes[i];
            d.run_last     = (i == run_bytes.size() - 1);
            d.message_done = msg_end && d.run_last;
            expected_bytes.push_back(d);
         end
      endfunction

      function void check_decoded(logic [7:0] b, logic last, logic done);
         decoded_type e;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected output transfer: byte %h last %b done %b",
                     $time, b, last, done);
            errors++;
            return;
         end
         e = expected_bytes.pop_front();
         checked++;
         if (b !== e.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h actual %h", $time, e.out_byte, b);
            errors++;
         end
         if (last !== e.run_last) begin
            $display("%0t: run_last mismatch: expected %b actual %b", $time, e.run_last, last);
            errors++;
         end
         if (done !== e.message_done) begin
            $display("%0t: message_done mismatch: expected %b actual %b",
                     $time, e.message_done, done);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;

   int unsigned        sender_idle_pct = 15;
   int unsigned        receiver_idle_pct = 47;
   int                 bytes_sent = 0;
   decode_checker_type sb = new();

   percent_url_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_decoded(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   task automatic send_encoded(logic [7:0] b, logic msg_end);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= msg_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_encoded(b, msg_end);
      bytes_sent++;
   endtask

   task automatic send_text(string s, logic end_at_last);
      for (int i = 0; i < s.len(); i++) begin
         send_encoded(s[i], end_at_last && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] rand_hex();
      int unsigned k;
      k = $urandom_range(21);
      if (k < 10) return 8'(8'h30 + k);
      if (k < 16) return 8'(8'h61 + k - 10);
      return 8'(8'h41 + k - 16);
   endfunction

   function automatic logic [7:0] rand_nonhex();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (sb.hex_value(b) >= 0);
      return b;
   endfunction

   function automatic logic rand_end();
      return ($urandom_range(11) == 0);
   endfunction

   // well-formed escapes most often, some broken ones, plus and raw bytes
   task automatic send_random_word();
      int unsigned k;
      logic [7:0]  hi;
      k = $urandom_range(99);
      if (k < 45) begin
         hi = ($urandom_range(4) == 0) ? 8'h33 : rand_hex();
         send_encoded(CharPct, rand_end());
         send_encoded(hi, rand_end());
         send_encoded(rand_hex(), rand_end());
      end else if (k < 55) begin
         send_encoded(CharPct, rand_end());
         send_encoded(rand_nonhex(), rand_end());
      end else if (k < 65) begin
         send_encoded(CharPct, rand_end());
         send_encoded(rand_hex(), rand_end());
         send_encoded(rand_nonhex(), rand_end());
      end else if (k < 75) begin
         send_encoded(CharPlus, rand_end());
      end else begin
         send_encoded(8'($urandom_range(255)), rand_end());
      end
   endtask

   task automatic run_random(int unsigned snd_pct, int unsigned rcv_pct, int n);
      int stop_at;
      sender_idle_pct   = snd_pct;
      receiver_idle_pct = rcv_pct;
      stop_at = bytes_sent + n;
      while (bytes_sent < stop_at) send_random_word();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_encoded(8'h00, 1'b0);
      send_encoded(8'hFF, 1'b0);
      send_text("+%41%39%fF%G%a+%%20", 1'b0);
      send_text("%B", 1'b1);
      send_text("%", 1'b1);
      send_text("x", 1'b1);

      run_random(15, 47, 78);
      run_random(47, 15, 78);
      run_random(0, 0, 78);
      send_encoded(8'($urandom_range(255)), 1'b1);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d encoded bytes in %0d messages; checked %0d decoded bytes",
               bytes_sent, sb.messages, sb.checked);
      $display("Escapes decoded: %0d, digit escapes kept literal: %0d, errors: %0d",
               sb.escapes, sb.digit_escapes, sb.errors);
      if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
         $display("percent_url_decoder_core_tb: PASS");
      end else begin
         $display("%0d expected bytes never arrived", sb.expected_bytes.size());
         $display("percent_url_decoder_core_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timeout at %0t", $time);
      $display("percent_url_decoder_core_tb: FAIL");
      $finish;
   end

endmodule
